[sv/trf_pkg.sv]
// ----------------------------------------------------------------------------
// trf_pkg: shared types and constants of the toon rim fragment shader
// Request payloads, configuration register indexes and pipeline depths.
// ----------------------------------------------------------------------------
`default_nettype none

package trf_pkg;

  // One fragment request: view-space normal (Q1.14) and position (Q7.8).
  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } trf_frag_t;

  // One shaded color, unsigned Q2.14 per channel.
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } trf_color_t;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOON_SOFTNESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIM_DIRECTION  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIM_BAND       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_COLOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_COLOR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RIM_COLOR      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_COLOR    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_VIEW = 3'd7;

  // Fixed point one in Q1.15.
  localparam logic [15:0] ONE_Q15 = 16'd32768;

  // Depth of the cosine unit and of the smoothstep pipe.
  localparam int COS_LAT    = 43;
  localparam int SMOOTH_LAT = 19;

endpackage

`default_nettype wire

[sv/trf_chan_if.sv]
// ----------------------------------------------------------------------------
// trf_chan_if: valid/ready channel
// Carries one request per accepted handshake; payload type is a parameter.
// ----------------------------------------------------------------------------
`default_nettype none

interface trf_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

[sv/trf_cos.sv]
// ----------------------------------------------------------------------------
// trf_cos: pipelined clamped cosine between two vectors
// Forms dot product and squared lengths, takes both square roots one bit per
// stage, then divides one quotient bit per stage. Result Q1.15 in [0, 1.0].
// ----------------------------------------------------------------------------
`default_nettype none

module trf_cos (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [16:0] a_i [3],
  input  wire logic signed [16:0] b_i [3],
  output logic [15:0]             cos_o
);

  localparam int SqW = 21;  // root bits of a 42-bit scaled square length
  localparam int QW  = 17;  // quotient bits before clamping

  // Component products.
  logic signed [33:0] pab_q [3];
  logic signed [33:0] paa_q [3];
  logic signed [33:0] pbb_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        pab_q[k] <= a_i[k] * b_i[k];
        paa_q[k] <= a_i[k] * a_i[k];
        pbb_q[k] <= b_i[k] * b_i[k];
      end
    end
  end

  // Sums of the products.
  logic signed [35:0] dot_d, laa_d, lbb_d;

  always_comb begin
    dot_d = 36'(pab_q[0]) + 36'(pab_q[1]) + 36'(pab_q[2]);
    laa_d = 36'(paa_q[0]) + 36'(paa_q[1]) + 36'(paa_q[2]);
    lbb_d = 36'(pbb_q[0]) + 36'(pbb_q[1]) + 36'(pbb_q[2]);
  end

  logic signed [35:0] dot_q    [SqW+1];
  logic [41:0]        rem_a_q  [SqW+1];
  logic [41:0]        rem_b_q  [SqW+1];
  logic [SqW-1:0]     root_a_q [SqW+1];
  logic [SqW-1:0]     root_b_q [SqW+1];

  // Squared lengths scaled by 256 enter the square root chain.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q[0]    <= dot_d;
      rem_a_q[0]  <= {laa_d[33:0], 8'd0};
      rem_b_q[0]  <= {lbb_d[33:0], 8'd0};
      root_a_q[0] <= '0;
      root_b_q[0] <= '0;
    end
  end

  // Square root, one result bit per stage, remainder kept as x - root^2.
  for (genvar j = 0; j < SqW; j++) begin : g_sqrt
    localparam int B = SqW - 1 - j;
    logic [43:0] trial_a, trial_b;

    assign trial_a = (44'(root_a_q[j]) << (B + 1)) + (44'(1) << (2 * B));
    assign trial_b = (44'(root_b_q[j]) << (B + 1)) + (44'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dot_q[j+1] <= dot_q[j];
        if (44'(rem_a_q[j]) >= trial_a) begin
          rem_a_q[j+1]  <= rem_a_q[j] - trial_a[41:0];
          root_a_q[j+1] <= root_a_q[j] | (SqW'(1) << B);
        end else begin
          rem_a_q[j+1]  <= rem_a_q[j];
          root_a_q[j+1] <= root_a_q[j];
        end
        if (44'(rem_b_q[j]) >= trial_b) begin
          rem_b_q[j+1]  <= rem_b_q[j] - trial_b[41:0];
          root_b_q[j+1] <= root_b_q[j] | (SqW'(1) << B);
        end else begin
          rem_b_q[j+1]  <= rem_b_q[j];
          root_b_q[j+1] <= root_b_q[j];
        end
      end
    end
  end

  // Divisor is the product of the lengths; the dividend is dot scaled by 2^23.
  logic [41:0] m_d_q;
  logic [56:0] m_num_q;
  logic        m_zero_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_d_q    <= root_a_q[SqW] * root_b_q[SqW];
      m_num_q  <= {dot_q[SqW][33:0], 23'd0};
      m_zero_q <= (dot_q[SqW] <= 36'sd0) || (root_a_q[SqW] == '0) ||
                  (root_b_q[SqW] == '0);
    end
  end

  logic [58:0]   dv_rem_q [QW+1];
  logic [41:0]   dv_d_q   [QW+1];
  logic [QW-1:0] dv_quo_q [QW+1];
  logic          dv_zero_q[QW+1];
  logic          dv_ovf_q [QW+1];

  // Quotients of 2^17 and more saturate anyway; flag them up front.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_rem_q[0]  <= 59'(m_num_q);
      dv_d_q[0]    <= m_d_q;
      dv_quo_q[0]  <= '0;
      dv_zero_q[0] <= m_zero_q;
      dv_ovf_q[0]  <= 59'(m_num_q) >= {m_d_q, 17'd0};
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [58:0] shd;

    assign shd = 59'(dv_d_q[j]) << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_d_q[j+1]    <= dv_d_q[j];
        dv_zero_q[j+1] <= dv_zero_q[j];
        dv_ovf_q[j+1]  <= dv_ovf_q[j];
        if (dv_rem_q[j] >= shd) begin
          dv_rem_q[j+1] <= dv_rem_q[j] - shd;
          dv_quo_q[j+1] <= dv_quo_q[j] | (QW'(1) << B);
        end else begin
          dv_rem_q[j+1] <= dv_rem_q[j];
          dv_quo_q[j+1] <= dv_quo_q[j];
        end
      end
    end
  end

  // Clamp to [0, 1.0]; a zero-length vector or obtuse angle gives zero.
  logic [15:0] cos_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (dv_zero_q[QW]) begin
        cos_q <= '0;
      end else if (dv_ovf_q[QW] || (dv_quo_q[QW] > QW'(trf_pkg::ONE_Q15))) begin
        cos_q <= trf_pkg::ONE_Q15;
      end else begin
        cos_q <= dv_quo_q[QW][15:0];
      end
    end
  end

  assign cos_o = cos_q;

endmodule

`default_nettype wire

[sv/toon_rim_fragment_shade_top.sv]
// ----------------------------------------------------------------------------
// toon_rim_fragment_shade_top: cel shading with rim light, one fragment a clock
// Eight configuration registers, a fragment request channel and a color
// request channel.
// ----------------------------------------------------------------------------
// Usage:
//   frag_i carries one fragment request (normal Q1.14, position Q7.8) per
//   valid/ready handshake; color_o returns one saturated Q2.14 RGB color for
//   each, in order. Configuration is written through cfg_we_i, cfg_idx_i and
//   cfg_data_i while no fragment is in flight.
//   Throughput is one fragment per clock while color_o is not stalled: every
//   unit (the two cosine units with their bit-per-stage square roots and
//   dividers, the two smoothstep dividers and the color multipliers) is fully
//   pipelined. Reset clears the configuration registers and the valid bits
//   to zero, which empties the pipeline.
//   When the receiver holds color_o.ready low with a color waiting, the
//   whole pipeline freezes and frag_i.ready drops in the same cycle; nothing
//   is lost or repeated, and flow resumes when the color is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module toon_rim_fragment_shade_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [trf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [trf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  trf_chan_if.sink                               frag_i,
  trf_chan_if.source                             color_o
);

  localparam int PipeLat = 1 + trf_pkg::COS_LAT + 2 + trf_pkg::SMOOTH_LAT + 4;
  localparam int DivW    = 15;  // smoothstep quotient bits

  // Configuration registers.
  logic [15:0] softness_q;
  logic [15:0] rim_dir_q;
  logic [31:0] rim_band_q;
  logic [47:0] amb_q, base_q, rimc_q, light_q, light_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      softness_q  <= '0;
      rim_dir_q   <= '0;
      rim_band_q  <= '0;
      amb_q       <= '0;
      base_q      <= '0;
      rimc_q      <= '0;
      light_q     <= '0;
      light_pos_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        trf_pkg::CFG_TOON_SOFTNESS:  softness_q  <= cfg_data_i[15:0];
        trf_pkg::CFG_RIM_DIRECTION:  rim_dir_q   <= cfg_data_i[15:0];
        trf_pkg::CFG_RIM_BAND:       rim_band_q  <= cfg_data_i[31:0];
        trf_pkg::CFG_AMBIENT_COLOR:  amb_q       <= cfg_data_i;
        trf_pkg::CFG_BASE_COLOR:     base_q      <= cfg_data_i;
        trf_pkg::CFG_RIM_COLOR:      rimc_q      <= cfg_data_i;
        trf_pkg::CFG_LIGHT_COLOR:    light_q     <= cfg_data_i;
        trf_pkg::CFG_LIGHT_POS_VIEW: light_pos_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a finished color is stalled.
  logic              en;
  logic [PipeLat-1:0] vld_q;

  assign en           = !vld_q[PipeLat-1] || color_o.ready;
  assign frag_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeLat-2:0], frag_i.valid};
    end
  end

  // Input stage: normal, view vector and light vector.
  logic signed [15:0] nrm [3];
  logic signed [15:0] pos [3];
  logic signed [16:0] n_q [3];
  logic signed [16:0] v_q [3];
  logic signed [16:0] l_q [3];

  always_comb begin
    nrm[0] = frag_i.data.normal_x;
    nrm[1] = frag_i.data.normal_y;
    nrm[2] = frag_i.data.normal_z;
    pos[0] = frag_i.data.pos_x;
    pos[1] = frag_i.data.pos_y;
    pos[2] = frag_i.data.pos_z;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n_q[k] <= 17'(nrm[k]);
        v_q[k] <= -17'(pos[k]);
        l_q[k] <= 17'($signed(light_pos_q[32-16*k +: 16])) - 17'(pos[k]);
      end
    end
  end

  // Cosines of the normal against the light and the view vectors.
  logic [15:0] ndl, ndv;

  trf_cos u_cos_l (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (n_q),
    .b_i   (l_q),
    .cos_o (ndl)
  );

  trf_cos u_cos_v (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (n_q),
    .b_i   (v_q),
    .cos_o (ndv)
  );

  // Rim direction weight and rim factor.
  logic signed [15:0] dir;
  logic [15:0]        mask, dir_mag;
  logic [31:0]        w_sum;
  logic [15:0]        w_q, rim_q, fin_q, ndl_q1, ndl_q2;
  logic [31:0]        fin_prod;

  always_comb begin
    dir     = $signed(rim_dir_q);
    dir_mag = dir[15] ? 16'(-17'(dir)) : rim_dir_q;
    if (dir > 16'sd0) begin
      mask = ndl;
    end else if (dir < 16'sd0) begin
      mask = trf_pkg::ONE_Q15 - ndl;
    end else begin
      mask = trf_pkg::ONE_Q15;
    end
    w_sum    = (32'(mask) * 32'(dir_mag)) +
               (32'(trf_pkg::ONE_Q15 - dir_mag) << 15);
    fin_prod = 32'(rim_q) * 32'(w_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q    <= w_sum[30:15];
      rim_q  <= trf_pkg::ONE_Q15 - ndv;
      ndl_q1 <= ndl;
      fin_q  <= fin_prod[30:15];
      ndl_q2 <= ndl_q1;
    end
  end

  // Smoothstep edges: lane 0 is the diffuse band, lane 1 the rim band.
  logic signed [18:0] sm_x  [2];
  logic signed [18:0] sm_e0 [2];
  logic signed [18:0] sm_e1 [2];
  logic signed [18:0] thr, half;

  always_comb begin
    half     = 19'(softness_q[15:1]);
    thr      = 19'sd32768 - 19'(rim_band_q[31:16]);
    sm_x[0]  = 19'(ndl_q2);
    sm_e0[0] = 19'sd16384 - half;
    sm_e1[0] = 19'sd16384 + half;
    sm_x[1]  = 19'(fin_q);
    sm_e0[1] = thr - 19'(rim_band_q[15:0]);
    sm_e1[1] = thr + 19'(rim_band_q[15:0]);
  end

  logic [32:0]     sm_rem_q [2][DivW+1];
  logic [17:0]     sm_den_q [2][DivW+1];
  logic [DivW-1:0] sm_quo_q [2][DivW+1];
  logic            sm_f0_q  [2][DivW+1];
  logic            sm_f1_q  [2][DivW+1];
  logic [15:0]     t_q      [2];
  logic [30:0]     sq_q     [2];
  logic [16:0]     m_q      [2];
  logic [15:0]     sm_res_q [2];

  for (genvar k = 0; k < 2; k++) begin : g_smooth
    logic               inv, below;
    logic signed [18:0] xd, dd;
    logic [47:0]        poly;

    // Band setup: an empty band turns into a step at the lower edge.
    always_comb begin
      inv   = sm_e1[k] <= sm_e0[k];
      below = sm_x[k] < sm_e0[k];
      xd    = sm_x[k] - sm_e0[k];
      dd    = sm_e1[k] - sm_e0[k];
      poly  = 48'(sq_q[k]) * 48'(m_q[k]);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sm_rem_q[k][0] <= {xd[17:0], 15'd0};
        sm_den_q[k][0] <= dd[17:0];
        sm_quo_q[k][0] <= '0;
        sm_f0_q[k][0]  <= inv ? below : (sm_x[k] <= sm_e0[k]);
        sm_f1_q[k][0]  <= inv ? !below : (sm_x[k] >= sm_e1[k]);
      end
    end

    // Position inside the band, one quotient bit per stage.
    for (genvar j = 0; j < DivW; j++) begin : g_div
      localparam int B = DivW - 1 - j;
      logic [32:0] shd;

      assign shd = 33'(sm_den_q[k][j]) << B;

      always_ff @(posedge clk_i) begin
        if (en) begin
          sm_den_q[k][j+1] <= sm_den_q[k][j];
          sm_f0_q[k][j+1]  <= sm_f0_q[k][j];
          sm_f1_q[k][j+1]  <= sm_f1_q[k][j];
          if (sm_rem_q[k][j] >= shd) begin
            sm_rem_q[k][j+1] <= sm_rem_q[k][j] - shd;
            sm_quo_q[k][j+1] <= sm_quo_q[k][j] | (DivW'(1) << B);
          end else begin
            sm_rem_q[k][j+1] <= sm_rem_q[k][j];
            sm_quo_q[k][j+1] <= sm_quo_q[k][j];
          end
        end
      end
    end

    // Clamp t, then evaluate t*t*(3 - 2t) in two multiply stages.
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (sm_f0_q[k][DivW]) begin
          t_q[k] <= '0;
        end else if (sm_f1_q[k][DivW]) begin
          t_q[k] <= trf_pkg::ONE_Q15;
        end else begin
          t_q[k] <= 16'(sm_quo_q[k][DivW]);
        end
        sq_q[k]     <= 31'(32'(t_q[k]) * 32'(t_q[k]));
        m_q[k]      <= 17'(98304) - {t_q[k], 1'b0};
        sm_res_q[k] <= poly[45:30];
      end
    end
  end

  // Color blend: ambient + base * diffuse, mixed toward the rim color, times the light color.
  logic [16:0] base_mix_q [3];
  logic [15:0] amt_q, om_q;
  logic [32:0] pa_q [3];
  logic [31:0] pb_q [3];
  logic [16:0] mix_q [3];
  logic [15:0] col_q [3];
  logic [31:0] bd_prod [3];
  logic [33:0] mix_sum [3];
  logic [32:0] lit_prod [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bd_prod[k]  = 32'(base_q[32-16*k +: 16]) * 32'(sm_res_q[0]);
      mix_sum[k]  = 34'(pa_q[k]) + 34'(pb_q[k]);
      lit_prod[k] = 33'(mix_q[k]) * 33'(light_q[32-16*k +: 16]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      amt_q <= sm_res_q[1];
      om_q  <= trf_pkg::ONE_Q15 - sm_res_q[1];
      for (int k = 0; k < 3; k++) begin
        base_mix_q[k] <= 17'(amb_q[32-16*k +: 16]) + 17'(bd_prod[k][31:15]);
        pa_q[k]       <= 33'(base_mix_q[k]) * 33'(om_q);
        pb_q[k]       <= 32'(rimc_q[32-16*k +: 16]) * 32'(amt_q);
        mix_q[k]      <= mix_sum[k][31:15];
        // Saturate the lit color to the top of Q2.14.
        col_q[k]      <= (lit_prod[k][32:14] > 19'd65535) ? 16'hFFFF
                                                           : lit_prod[k][29:14];
      end
    end
  end

  assign color_o.valid      = vld_q[PipeLat-1];
  assign color_o.data.red   = col_q[0];
  assign color_o.data.green = col_q[1];
  assign color_o.data.blue  = col_q[2];

endmodule

`default_nettype wire

[sv/trf_checker.sv]
// ----------------------------------------------------------------------------
// trf_checker: port-level checks of the toon rim fragment shader
// Watches the handshakes on both channels and the stall coupling between them.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        frag_valid_i,
  input wire logic        frag_ready_i,
  input wire logic        color_valid_i,
  input wire logic        color_ready_i,
  input wire logic [47:0] color_data_i
);

  // A stalled color stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    color_valid_i && !color_ready_i |=> color_valid_i)
    else $error("color request dropped while stalled");

  // A stalled color keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    color_valid_i && !color_ready_i |=> $stable(color_data_i))
    else $error("color payload changed while stalled");

  // No new fragment is taken while the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    color_valid_i && !color_ready_i |-> !frag_ready_i)
    else $error("fragment accepted during output stall");

  // Without an output stall the block always takes fragments.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !color_valid_i || color_ready_i |-> frag_ready_i)
    else $error("fragment refused without output stall");

  // Nothing leaves the block in the cycle after reset releases.
  assert property (@(posedge clk_i)
    !rst_ni |=> !color_valid_i)
    else $error("color request right after reset");

endmodule

bind toon_rim_fragment_shade_top trf_checker u_trf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .frag_valid_i  (frag_i.valid),
  .frag_ready_i  (frag_i.ready),
  .color_valid_i (color_o.valid),
  .color_ready_i (color_o.ready),
  .color_data_i  (color_o.data)
);

`default_nettype wire
